// ===== sv/prvd_pkg.sv =====
// ----------------------------------------------------------------------------
// prvd_pkg
// shared types, constants and helper functions for the voxel dedup transform
// ----------------------------------------------------------------------------
package prvd_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POSE,
        ST_ROT,
        ST_RANGE,
        ST_KEY,
        ST_HASH,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_XFORM,
        ST_EMIT
    } state_t;

    localparam logic [1:0] CFG_MIN_RANGE = 2'd0;
    localparam logic [1:0] CFG_MAX_RANGE = 2'd1;
    localparam logic [1:0] CFG_INV_LEAF  = 2'd2;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_POSE  = 1'b1;

    localparam logic [47:0] MIN_RANGE_RESET = 48'd5898;
    localparam logic [47:0] MAX_RANGE_RESET = 48'd1638400;
    localparam logic [25:0] INV_LEAF_RESET  = 26'd1310720;
    localparam logic [25:0] INV_LEAF_CAP    = 26'd65536000;

    // golden-ratio hash multiplier, split in halves
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

    localparam logic signed [39:0] Q30_ONE = 40'sd1073741824;

    // quaternion product order: xx yy zz xy xz yz xw yw zw
    function automatic logic [1:0] quat_sel_a(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd1, 4'd5, 4'd7: r = 2'd1;
            4'd2, 4'd8:       r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] quat_sel_b(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd1, 4'd3:       r = 2'd1;
            4'd2, 4'd4, 4'd5: r = 2'd2;
            4'd6, 4'd7, 4'd8: r = 2'd3;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // row and column of a matrix element index
    function automatic logic [1:0] mat_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mat_col(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // add half, floor shift by 30
    function automatic logic signed [35:0] round30(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p + 66'sd536870912;
        return s[65:30];
    endfunction

    function automatic logic signed [39:0] ext40(input logic signed [35:0] v);
        return {{4{v[35]}}, v};
    endfunction

    function automatic logic signed [31:0] rot_diag(input logic signed [35:0] a,
                                                    input logic signed [35:0] b);
        return sat32(Q30_ONE - ((ext40(a) + ext40(b)) <<< 1));
    endfunction

    function automatic logic signed [31:0] rot_add(input logic signed [35:0] a,
                                                   input logic signed [35:0] b);
        return sat32((ext40(a) + ext40(b)) <<< 1);
    endfunction

    function automatic logic signed [31:0] rot_sub(input logic signed [35:0] a,
                                                   input logic signed [35:0] b);
        return sat32((ext40(a) - ext40(b)) <<< 1);
    endfunction

endpackage

// ===== sv/prvd_mul.sv =====
// ----------------------------------------------------------------------------
// prvd_mul
// shared 33x33 signed multiplier with registered product
// ----------------------------------------------------------------------------
module prvd_mul
    import prvd_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign p = prod_reg;

endmodule

// ===== sv/prvd_seen_ram.sv =====
// ----------------------------------------------------------------------------
// prvd_seen_ram
// seen-voxel table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module prvd_seen_ram
    import prvd_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/point_range_voxel_dedup_transform_unit.sv =====
// ----------------------------------------------------------------------------
// point_range_voxel_dedup_transform_unit
// range gate, voxel dedup over a hashed seen table, rigid transform of points
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer around a single registered
// 33x33 multiplier and the seen table memory. A point item passes through
// range check, key quantization, hashing, slot reduction (reciprocal estimate
// and one correcting subtract), table probes (1 to PROBE_LIMIT probes), the
// transform and hand-off to the output register, and then returns to idle;
// no new item is taken until it is back in idle. A point whose key is already
// in the table is dropped after its probe, as are a non-finite point and a
// point out of range. A pose item is followed by a clearing pass over all
// SEEN_DEPTH table entries; the same pass runs after reset, and during it no
// item is accepted. A finished result sits in an output register, so the
// next item is taken while it waits; a second result waits in the sequencer
// until the output register is free.
module point_range_voxel_dedup_transform_unit
    import prvd_pkg::*;
#(
    parameter int SEEN_DEPTH    = 4096,
    parameter int PROBE_LIMIT   = 8,
    parameter int AXIS_KEY_BITS = 21
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // coord_x, coord_y, coord_z, quat_x, quat_y, quat_z, quat_w
    input  logic [223:0]   s_axis_tdata,
    // command, point_valid
    input  logic [1:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // map_x, map_y, map_z, voxel_key, zero pad
    output logic [159:0]   m_axis_tdata,
    // table_overflow
    output logic [0:0]     m_axis_tuser,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [47:0]    cfg_data
);

    localparam int IDXW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int PCW  = $clog2(PROBE_LIMIT + 1);
    localparam int RECIP_SHIFT = 31 + IDXW;
    localparam logic [31:0]     DEPTH_W    = 32'(SEEN_DEPTH);
    localparam logic [31:0]     HASH_RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(SEEN_DEPTH));
    localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(SEEN_DEPTH - 1);
    localparam logic [PCW-1:0]  LAST_PROBE = PCW'(PROBE_LIMIT - 1);

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [IDXW-1:0] slot_reg, slot_next;
    logic [PCW-1:0] probe_reg, probe_next;
    logic out_valid_reg, out_valid_next;

    logic [47:0] min_reg, max_reg;
    logic [25:0] leaf_reg;
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] rot_next [9];
    logic signed [31:0] trans_reg [3];
    logic signed [31:0] trans_next [3];

    logic signed [31:0] c_reg [3];
    logic signed [31:0] c_next [3];
    logic signed [31:0] q_reg [4];
    logic signed [31:0] q_next [4];
    logic signed [35:0] pq_reg [9];
    logic signed [35:0] pq_next [9];
    logic signed [37:0] xacc_reg [3];
    logic signed [37:0] xacc_next [3];
    logic [63:0] r2_reg, r2_next;
    logic [62:0] key_reg, key_next;
    logic [31:0] hs_reg, hs_next;
    logic ovf_reg, ovf_next;
    logic [159:0] odata_reg, odata_next;
    logic ouser_reg, ouser_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [3:0] k4, kp4;
    logic [25:0] leaf_c;
    logic [63:0] r2_sum;
    logic [31:0] quo;
    logic [31:0] rem_t;
    logic signed [35:0] prod_r;
    logic signed [31:0] c_pick;
    logic [1:0] prow;

    logic ram_we, ram_re;
    logic [IDXW-1:0] ram_waddr;
    logic [63:0] ram_wdata, ram_rdata;

    prvd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    prvd_seen_ram #(
        .DEPTH (SEEN_DEPTH),
        .AW    (IDXW)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign k4     = cnt_reg[3:0];
    assign kp4    = cnt_reg[3:0] - 4'd1;
    assign leaf_c = (leaf_reg > INV_LEAF_CAP) ? INV_LEAF_CAP : leaf_reg;
    assign r2_sum = r2_reg + mul_p[63:0];
    // quotient estimate is low by at most one
    assign quo    = 32'(mul_p[63:0] >> RECIP_SHIFT);
    assign rem_t  = hs_reg - mul_p[31:0];
    assign prod_r = round30(mul_p);
    assign prow   = mat_row(kp4);

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    c_pick = c_reg[0];
            2'd1:    c_pick = c_reg[1];
            default: c_pick = c_reg[2];
        endcase
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POSE:
            begin
                mul_a = {q_reg[quat_sel_a(k4)][31], q_reg[quat_sel_a(k4)]};
                mul_b = {q_reg[quat_sel_b(k4)][31], q_reg[quat_sel_b(k4)]};
            end
            ST_RANGE:
            begin
                mul_a = {c_pick[31], c_pick};
                mul_b = {c_pick[31], c_pick};
            end
            ST_KEY:
            begin
                mul_a = {c_pick[31], c_pick};
                mul_b = {7'd0, leaf_c};
            end
            ST_HASH:
            begin
                mul_a = (cnt_reg == 6'd1) ? {2'b00, key_reg[62:32]}
                                          : {1'b0, key_reg[31:0]};
                mul_b = (cnt_reg == 6'd2) ? {1'b0, HASH_MUL_HI}
                                          : {1'b0, HASH_MUL_LO};
            end
            ST_MOD:
            begin
                if (cnt_reg == 6'd0)
                begin
                    mul_a = {1'b0, hs_reg};
                    mul_b = {1'b0, HASH_RECIP};
                end
                else
                begin
                    mul_a = {1'b0, quo};
                    mul_b = {1'b0, DEPTH_W};
                end
            end
            ST_XFORM:
            begin
                mul_a = (k4 > 4'd8) ? '0 : {rot_reg[k4][31], rot_reg[k4]};
                mul_b = {c_reg[mat_col(k4)][31], c_reg[mat_col(k4)]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        probe_next     = probe_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        rot_next       = rot_reg;
        trans_next     = trans_reg;
        c_next         = c_reg;
        q_next         = q_reg;
        pq_next        = pq_reg;
        xacc_next      = xacc_reg;
        r2_next        = r2_reg;
        key_next       = key_reg;
        hs_next        = hs_reg;
        ovf_next       = ovf_reg;
        odata_next     = odata_reg;
        ouser_next     = ouser_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = {1'b1, key_reg};
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    c_next[0] = s_axis_tdata[31:0];
                    c_next[1] = s_axis_tdata[63:32];
                    c_next[2] = s_axis_tdata[95:64];
                    q_next[0] = s_axis_tdata[127:96];
                    q_next[1] = s_axis_tdata[159:128];
                    q_next[2] = s_axis_tdata[191:160];
                    q_next[3] = s_axis_tdata[223:192];
                    cnt_next  = '0;
                    r2_next   = '0;
                    key_next  = '0;
                    if (s_axis_tuser[0] == CMD_POSE)
                        state_next = ST_POSE;
                    else if (s_axis_tuser[1])
                        state_next = ST_RANGE;
                end
            end
            ST_POSE:
            begin
                if (cnt_reg != 6'd0)
                    pq_next[kp4] = prod_r;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd9)
                    state_next = ST_ROT;
            end
            ST_ROT:
            begin
                // pq order: xx yy zz xy xz yz xw yw zw
                rot_next[0] = rot_diag(pq_reg[1], pq_reg[2]);
                rot_next[1] = rot_sub(pq_reg[3], pq_reg[8]);
                rot_next[2] = rot_add(pq_reg[4], pq_reg[7]);
                rot_next[3] = rot_add(pq_reg[3], pq_reg[8]);
                rot_next[4] = rot_diag(pq_reg[0], pq_reg[2]);
                rot_next[5] = rot_sub(pq_reg[5], pq_reg[6]);
                rot_next[6] = rot_sub(pq_reg[4], pq_reg[7]);
                rot_next[7] = rot_add(pq_reg[5], pq_reg[6]);
                rot_next[8] = rot_diag(pq_reg[0], pq_reg[1]);
                trans_next  = c_reg;
                slot_next   = '0;
                state_next  = ST_CLEAR;
            end
            ST_RANGE:
            begin
                if (cnt_reg != 6'd0)
                    r2_next = r2_sum;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next = '0;
                    if (r2_sum < {min_reg, 16'd0} || r2_sum > {max_reg, 16'd0})
                        state_next = ST_IDLE;
                    else
                        state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                // floor(c * leaf) >> 32, low index bits
                if (cnt_reg == 6'd1)
                    key_next[0 +: AXIS_KEY_BITS] = mul_p[32 +: AXIS_KEY_BITS];
                else if (cnt_reg == 6'd2)
                    key_next[AXIS_KEY_BITS +: AXIS_KEY_BITS] = mul_p[32 +: AXIS_KEY_BITS];
                else if (cnt_reg == 6'd3)
                    key_next[2*AXIS_KEY_BITS +: AXIS_KEY_BITS] = mul_p[32 +: AXIS_KEY_BITS];
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next   = '0;
                    hs_next    = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                // bits 63:32 of the low 64-bit product
                if (cnt_reg == 6'd1)
                    hs_next = hs_reg + mul_p[63:32];
                else if (cnt_reg != 6'd0)
                    hs_next = hs_reg + mul_p[31:0];
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next   = '0;
                    slot_next  = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // reciprocal quotient, back-multiply, one correcting subtract
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                begin
                    slot_next  = (rem_t >= DEPTH_W) ? IDXW'(rem_t - DEPTH_W) : IDXW'(rem_t);
                    probe_next = '0;
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_PROBE_CMP;
            end
            ST_PROBE_CMP:
            begin
                cnt_next  = '0;
                xacc_next[0] = {{6{trans_reg[0][31]}}, trans_reg[0]};
                xacc_next[1] = {{6{trans_reg[1][31]}}, trans_reg[1]};
                xacc_next[2] = {{6{trans_reg[2][31]}}, trans_reg[2]};
                if (!ram_rdata[63])
                begin
                    ram_we     = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_XFORM;
                end
                else if (ram_rdata[62:0] == key_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    if (probe_reg == LAST_PROBE)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_XFORM;
                    end
                    else
                    begin
                        state_next = ST_PROBE_RD;
                    end
                end
            end
            ST_XFORM:
            begin
                if (cnt_reg != 6'd0)
                    xacc_next[prow] = xacc_reg[prow] + {{2{prod_r[35]}}, prod_r};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd9)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    odata_next = {1'b0, key_reg,
                                  sat32({{2{xacc_reg[2][37]}}, xacc_reg[2]}),
                                  sat32({{2{xacc_reg[1][37]}}, xacc_reg[1]}),
                                  sat32({{2{xacc_reg[0][37]}}, xacc_reg[0]})};
                    ouser_next     = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
            min_reg       <= MIN_RANGE_RESET;
            max_reg       <= MAX_RANGE_RESET;
            leaf_reg      <= INV_LEAF_RESET;
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                trans_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
            trans_reg     <= trans_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_RANGE: min_reg  <= cfg_data;
                    CFG_MAX_RANGE: max_reg  <= cfg_data;
                    CFG_INV_LEAF:  leaf_reg <= cfg_data[25:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        q_reg     <= q_next;
        pq_reg    <= pq_next;
        xacc_reg  <= xacc_next;
        r2_reg    <= r2_next;
        key_reg   <= key_next;
        hs_reg    <= hs_next;
        ovf_reg   <= ovf_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = odata_reg;
    assign m_axis_tuser[0] = ouser_reg;

endmodule
